// ----- rtl/thi_pkg.sv -----
// Shared types, constants and ROM tables for the thermistor table interpolator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package thi_pkg;

  localparam int ROM_SIZE      = 161;
  localparam int TABLE_ENTRIES = 161;
  localparam int SAMPLE_BITS   = 14;
  localparam int DEG_OFFSET    = 40;
  localparam int LIMIT = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                         ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);

  localparam int IDX_BITS  = 8;
  localparam int POS_BITS  = 9;
  localparam int ROM_BITS  = 14;
  localparam int REM_BITS  = ROM_BITS + 4;
  localparam int TEMP_BITS = 12;
  localparam int ACC_BITS  = 13;

  localparam logic signed [TEMP_BITS-1:0] TEMP_COLD = TEMP_BITS'(-10 * DEG_OFFSET);
  localparam logic signed [TEMP_BITS-1:0] TEMP_HOT  =
    TEMP_BITS'(10 * (LIMIT - 1 - DEG_OFFSET));

  localparam logic [ROM_BITS-1:0] SPI_ROM [ROM_SIZE] = '{
    14'd15813, 14'd15785, 14'd15754, 14'd15720, 14'd15683, 14'd15644, 14'd15602,
    14'd15556, 14'd15509, 14'd15458, 14'd15404, 14'd15347, 14'd15287, 14'd15224,
    14'd15158, 14'd15089, 14'd15018, 14'd14943, 14'd14865, 14'd14785, 14'd14702,
    14'd14618, 14'd14531, 14'd14441, 14'd14349, 14'd14254, 14'd14156, 14'd14054,
    14'd13950, 14'd13843, 14'd13733, 14'd13620, 14'd13504, 14'd13384, 14'd13262,
    14'd13136, 14'd13008, 14'd12875, 14'd12740, 14'd12602, 14'd12461, 14'd12313,
    14'd12163, 14'd12009, 14'd11853, 14'd11694, 14'd11532, 14'd11369, 14'd11202,
    14'd11035, 14'd10863, 14'd10691, 14'd10518, 14'd10342, 14'd10166, 14'd9989,
    14'd9812,  14'd9630,  14'd9450,  14'd9273,  14'd9092,  14'd8909,  14'd8731,
    14'd8548,  14'd8372,  14'd8192,  14'd8014,  14'd7837,  14'd7661,  14'd7487,
    14'd7314,  14'd7143,  14'd6973,  14'd6806,  14'd6640,  14'd6477,  14'd6316,
    14'd6157,  14'd6000,  14'd5846,  14'd5694,  14'd5546,  14'd5399,  14'd5256,
    14'd5115,  14'd4977,  14'd4842,  14'd4709,  14'd4580,  14'd4453,  14'd4330,
    14'd4209,  14'd4091,  14'd3976,  14'd3864,  14'd3754,  14'd3647,  14'd3543,
    14'd3441,  14'd3343,  14'd3247,  14'd3154,  14'd3062,  14'd2974,  14'd2889,
    14'd2805,  14'd2724,  14'd2646,  14'd2569,  14'd2494,  14'd2422,  14'd2353,
    14'd2285,  14'd2219,  14'd2156,  14'd2093,  14'd2033,  14'd1975,  14'd1918,
    14'd1864,  14'd1811,  14'd1759,  14'd1710,  14'd1661,  14'd1614,  14'd1569,
    14'd1526,  14'd1483,  14'd1442,  14'd1403,  14'd1364,  14'd1327,  14'd1290,
    14'd1255,  14'd1221,  14'd1188,  14'd1155,  14'd1124,  14'd1094,  14'd1064,
    14'd1035,  14'd1008,  14'd982,   14'd956,   14'd931,   14'd907,   14'd883,
    14'd859,   14'd836,   14'd814,   14'd792,   14'd771,   14'd751,   14'd731,
    14'd711,   14'd692,   14'd674,   14'd656,   14'd638,   14'd622,   14'd605
  };

  localparam logic [ROM_BITS-1:0] ANALOG_ROM [ROM_SIZE] = '{
    14'd987, 14'd986, 14'd984, 14'd982, 14'd979, 14'd977, 14'd974, 14'd971,
    14'd968, 14'd965, 14'd962, 14'd958, 14'd955, 14'd951, 14'd946, 14'd942,
    14'd938, 14'd933, 14'd928, 14'd923, 14'd918, 14'd913, 14'd907, 14'd902,
    14'd896, 14'd890, 14'd884, 14'd878, 14'd871, 14'd864, 14'd858, 14'd850,
    14'd843, 14'd836, 14'd828, 14'd820, 14'd812, 14'd804, 14'd796, 14'd787,
    14'd778, 14'd769, 14'd759, 14'd750, 14'd740, 14'd730, 14'd720, 14'd710,
    14'd699, 14'd689, 14'd678, 14'd668, 14'd657, 14'd646, 14'd635, 14'd624,
    14'd613, 14'd601, 14'd590, 14'd579, 14'd568, 14'd556, 14'd545, 14'd534,
    14'd523, 14'd512, 14'd500, 14'd489, 14'd478, 14'd468, 14'd457, 14'd446,
    14'd435, 14'd425, 14'd415, 14'd404, 14'd394, 14'd384, 14'd375, 14'd365,
    14'd356, 14'd346, 14'd337, 14'd328, 14'd319, 14'd311, 14'd302, 14'd294,
    14'd286, 14'd278, 14'd270, 14'd263, 14'd255, 14'd248, 14'd241, 14'd234,
    14'd228, 14'd221, 14'd215, 14'd209, 14'd203, 14'd197, 14'd191, 14'd186,
    14'd180, 14'd175, 14'd170, 14'd165, 14'd160, 14'd156, 14'd151, 14'd147,
    14'd143, 14'd139, 14'd135, 14'd131, 14'd127, 14'd123, 14'd120, 14'd116,
    14'd113, 14'd110, 14'd107, 14'd104, 14'd101, 14'd98,  14'd95,  14'd93,
    14'd90,  14'd88,  14'd85,  14'd83,  14'd81,  14'd78,  14'd76,  14'd74,
    14'd72,  14'd70,  14'd68,  14'd66,  14'd65,  14'd63,  14'd61,  14'd60,
    14'd58,  14'd57,  14'd55,  14'd54,  14'd52,  14'd51,  14'd49,  14'd48,
    14'd47,  14'd46,  14'd44,  14'd43,  14'd42,  14'd41,  14'd40,  14'd39,
    14'd38
  };

  // Search state carried through the lookup stages
  typedef struct packed {
    logic                   mode;
    logic [ROM_BITS-1:0]    sample;
    logic [POS_BITS-1:0]    pos;
  } srch_t;

  // Division state carried through the interpolation stages
  typedef struct packed {
    logic                        cold;
    logic                        hot;
    logic signed [ACC_BITS-1:0]  base;
    logic [REM_BITS-1:0]         rem;
    logic [ROM_BITS-1:0]         dvs;
    logic [3:0]                  quo;
  } div_t;

  function automatic logic [ROM_BITS-1:0] rom_read(input logic mode,
                                                   input logic [IDX_BITS-1:0] idx);
    logic [ROM_BITS-1:0] val;
    val = '0;
    if (int'(idx) < ROM_SIZE) begin
      val = mode ? ANALOG_ROM[int'(idx)] : SPI_ROM[int'(idx)];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/thermistor_table_interp_top.sv -----
// Thermistor sample to temperature: four search stages, one setup stage,
// two divide stages and an output stage. One beat per cycle
// sustained; a stall at the output holds the whole pipeline in place.
// Reset clears all stage valid bits; the tables are constant and need no fill.
// Depends on thi_pkg, thi_search_step and thi_divide_step.
`timescale 1ns / 1ps
`default_nettype none

module thermistor_table_interp_top
  import thi_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic                        mode_i,
  input  wire logic [13:0]                 sample_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic signed [TEMP_BITS-1:0]      temp_tenths_o
);

  localparam int SRCH_STAGES = 4;

  logic        advance;
  logic [7:0]  vld_q;
  srch_t       srch_q [SRCH_STAGES];
  srch_t       srch_d [SRCH_STAGES];
  srch_t       srch_in;
  div_t        set_d;
  div_t        div_q [3];
  div_t        div_d [2];
  logic signed [TEMP_BITS-1:0] temp_d;
  logic signed [TEMP_BITS-1:0] temp_q;

  // Whole pipeline moves unless the output beat is held
  assign advance = !(vld_q[7] && stall_i);
  assign stall_o = !advance;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  // Capture the beat and mask the sample
  always_comb begin
    srch_in        = '0;
    srch_in.mode   = mode_i;
    srch_in.sample = ROM_BITS'(sample_i[SAMPLE_BITS-1:0]);
    srch_in.pos    = '0;
  end

  // Search stages, two index bits each, highest first
  for (genvar g = 0; g < SRCH_STAGES; g++) begin : g_srch
    thi_search_step u_step (
      .level_i (2'(SRCH_STAGES - 1 - g)),
      .cur_i   ((g == 0) ? srch_in : srch_q[(g == 0) ? 0 : g - 1]),
      .nxt_o   (srch_d[g])
    );

    always_ff @(posedge clk_i) begin
      if (advance) begin
        srch_q[g] <= srch_d[g];
      end
    end
  end

  // Read the bracketing entries and set up the fraction
  always_comb begin
    logic [POS_BITS-1:0] k;
    logic [ROM_BITS-1:0] hi;
    logic [ROM_BITS-1:0] lo;
    logic [ROM_BITS-1:0] dif;
    logic [ROM_BITS-1:0] off;
    logic signed [ACC_BITS-1:0] kd;
    k   = srch_q[SRCH_STAGES-1].pos;
    hi  = rom_read(srch_q[SRCH_STAGES-1].mode, k[IDX_BITS-1:0] - IDX_BITS'(1));
    lo  = rom_read(srch_q[SRCH_STAGES-1].mode, k[IDX_BITS-1:0]);
    dif = hi - lo;
    off = srch_q[SRCH_STAGES-1].sample - lo;
    kd  = $signed(ACC_BITS'(k)) - ACC_BITS'(DEG_OFFSET);
    set_d      = '0;
    set_d.cold = (k == '0);
    set_d.hot  = (int'(k) >= LIMIT);
    set_d.base = (kd <<< 3) + (kd <<< 1);
    set_d.rem  = (REM_BITS'(off) << 3) + (REM_BITS'(off) << 1);
    set_d.dvs  = (dif == '0) ? ROM_BITS'(1) : dif;
    set_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      div_q[0] <= set_d;
    end
  end

  // Divide stages, two quotient bits each
  for (genvar g = 0; g < 2; g++) begin : g_div
    thi_divide_step u_step (
      .level_i (1'(1 - g)),
      .cur_i   (div_q[g]),
      .nxt_o   (div_d[g])
    );

    always_ff @(posedge clk_i) begin
      if (advance) begin
        div_q[g+1] <= div_d[g];
      end
    end
  end

  // Truncate toward zero and pick the clamped ends
  always_comb begin
    logic signed [ACC_BITS-1:0] q1;
    logic signed [ACC_BITS-1:0] res;
    q1  = $signed(ACC_BITS'(div_q[2].quo)) + ACC_BITS'(1);
    res = div_q[2].base - $signed(ACC_BITS'(div_q[2].quo));
    if ((div_q[2].rem != '0) && (div_q[2].base >= q1)) begin
      res = res - ACC_BITS'(1);
    end
    if (div_q[2].hot) begin
      temp_d = TEMP_HOT;
    end else if (div_q[2].cold) begin
      temp_d = TEMP_COLD;
    end else begin
      temp_d = res[TEMP_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      temp_q <= temp_d;
    end
  end

  assign valid_o       = vld_q[7];
  assign temp_tenths_o = temp_q;

  // Results stay inside the clamped range
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (temp_tenths_o >= TEMP_COLD) && (temp_tenths_o <= TEMP_HOT))
    else $error("temperature out of range");

  // A held output beat keeps its value
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o && $stable(temp_tenths_o))
    else $error("held beat changed");

  // An accepted input shows up at the output when nothing stalls
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) ##1 (!stall_o) ##1 (!stall_o) ##1 (!stall_o) ##1
    (!stall_o) ##1 (!stall_o) ##1 (!stall_o) ##1 (!stall_o) |=> valid_o)
    else $error("beat lost in pipeline");

endmodule

`default_nettype wire

// ----- rtl/thi_search_step.sv -----
// Two bits of the binary table search: first index whose entry is below the sample.
// Depends on thi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thi_search_step
  import thi_pkg::*;
(
  input  wire logic [1:0] level_i,
  input  var  srch_t      cur_i,
  output srch_t           nxt_o
);

  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] cand;
  logic [IDX_BITS-1:0] idx;
  logic                hit;
  logic [2:0]          bsel;

  // Try the higher bit, then the lower one
  always_comb begin
    pos  = cur_i.pos;
    cand = '0;
    idx  = '0;
    hit  = 1'b0;
    bsel = '0;
    for (int j = 1; j >= 0; j--) begin
      bsel = 3'({level_i, 1'b0}) + 3'(j);
      cand = pos + (POS_BITS'(1) << bsel);
      idx  = cand[IDX_BITS-1:0] - IDX_BITS'(1);
      hit  = (int'(idx) >= LIMIT) || (cur_i.sample > rom_read(cur_i.mode, idx));
      if (!hit) begin
        pos = cand;
      end
    end
    nxt_o     = cur_i;
    nxt_o.pos = pos;
  end

endmodule

`default_nettype wire

// ----- rtl/thi_divide_step.sv -----
// Two quotient bits of the restoring division of the interpolation fraction.
// Depends on thi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thi_divide_step
  import thi_pkg::*;
(
  input  wire logic level_i,
  input  var  div_t cur_i,
  output div_t      nxt_o
);

  logic [REM_BITS-1:0] rem;
  logic [REM_BITS-1:0] trial;
  logic [3:0]          quo;
  logic [1:0]          bsel;

  // Subtract the shifted divisor where it fits
  always_comb begin
    rem   = cur_i.rem;
    quo   = cur_i.quo;
    trial = '0;
    bsel  = '0;
    for (int j = 1; j >= 0; j--) begin
      bsel  = {level_i, 1'b0} + 2'(j);
      trial = REM_BITS'(cur_i.dvs) << bsel;
      if (rem >= trial) begin
        rem       = rem - trial;
        quo[bsel] = 1'b1;
      end
    end
    nxt_o     = cur_i;
    nxt_o.rem = rem;
    nxt_o.quo = quo;
  end

endmodule

`default_nettype wire
